[design/aabbct_pkg.sv]
// Shared constants, codes and controller/datapath types for the AABB collision table.
`default_nettype none

package aabbct_pkg;

    localparam int MAX_OBJECTS = 8;
    localparam int IDX_W       = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);

    localparam int MODE_W  = 3;
    localparam int TAG_W   = 8;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int BOX_W   = 2 * COORD_W + 2 * SIZE_W;
    localparam int ENT_W   = TAG_W + BOX_W;

    // Box word layout: {left, top, width, height}
    localparam int LEFT_LSB = 2 * SIZE_W + COORD_W;
    localparam int TOP_LSB  = 2 * SIZE_W;
    localparam int WID_LSB  = SIZE_W;
    localparam int HGT_LSB  = 0;

    localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OBSERVE = 3'd4;

    // Table write data source
    localparam logic [1:0] WR_ADD   = 2'd0;
    localparam logic [1:0] WR_UPD   = 2'd1;
    localparam logic [1:0] WR_SHIFT = 2'd2;

    typedef logic [MODE_W-1:0] t_mode;

    typedef struct packed {
        logic       load_in;
        logic       wr_en;
        logic [1:0] wr_src;
        logic       rd_next;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       cnt_clear;
        logic       idx_clear;
        logic       idx_inc;
        logic       obs_start;
        logic       obs_advance;
        logic       pend_push;
        logic       out_pair;
        logic       out_final;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  cnt_zero;
        logic  cnt_lt2;
        logic  match;
        logic  scan_end;
        logic  shift_end;
        logic  pair_end;
        logic  overlap;
        logic  pend_valid;
        logic  out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

[design/aabbct_if.sv]
// Valid/ready channel interfaces for the command input and the pair result output.
`default_nettype none

interface aabbct_in_if;
    logic                                  valid;
    logic                                  ready;
    logic        [aabbct_pkg::MODE_W-1:0]  mode;
    logic        [aabbct_pkg::TAG_W-1:0]   object_id;
    logic signed [aabbct_pkg::COORD_W-1:0] box_left;
    logic signed [aabbct_pkg::COORD_W-1:0] box_top;
    logic        [aabbct_pkg::SIZE_W-1:0]  box_width;
    logic        [aabbct_pkg::SIZE_W-1:0]  box_height;

    modport source (
        output valid, mode, object_id, box_left, box_top, box_width, box_height,
        input  ready
    );
    modport sink (
        input  valid, mode, object_id, box_left, box_top, box_width, box_height,
        output ready
    );
endinterface

interface aabbct_out_if;
    logic                           valid;
    logic                           ready;
    logic [aabbct_pkg::TAG_W-1:0]   first_id;
    logic [aabbct_pkg::TAG_W-1:0]   second_id;
    logic                           pair_found;
    logic                           last;

    modport source (
        output valid, first_id, second_id, pair_found, last,
        input  ready
    );
    modport sink (
        input  valid, first_id, second_id, pair_found, last,
        output ready
    );
endinterface

`default_nettype wire

[design/aabbct_ram.sv]
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module aabbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                 i_wr_data,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]                 o_rd_data_a,
    output logic      [WIDTH-1:0]                 o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

[design/aabbct_ctrl.sv]
// Controller state machine: sequences add, update, remove, clear and observe.
`default_nettype none

module aabbct_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output aabbct_pkg::t_dp_cmd      o_cmd,
    input  wire aabbct_pkg::t_dp_sts i_sts
);
    import aabbct_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_UPD_RD  = 4'd2;
    localparam logic [3:0] S_UPD_CHK = 4'd3;
    localparam logic [3:0] S_REM_RD  = 4'd4;
    localparam logic [3:0] S_REM_CHK = 4'd5;
    localparam logic [3:0] S_SHF_RD  = 4'd6;
    localparam logic [3:0] S_SHF_WR  = 4'd7;
    localparam logic [3:0] S_OBS_RD  = 4'd8;
    localparam logic [3:0] S_OBS_CHK = 4'd9;
    localparam logic [3:0] S_OBS_END = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_IDLE;
                case (i_sts.mode)
                    MODE_ADD: begin
                        if (!i_sts.full) begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_src  = WR_ADD;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    MODE_UPDATE: begin
                        o_cmd.idx_clear = 1'b1;
                        if (!i_sts.cnt_zero) begin
                            n_state = S_UPD_RD;
                        end
                    end
                    MODE_REMOVE: begin
                        o_cmd.idx_clear = 1'b1;
                        if (!i_sts.cnt_zero) begin
                            n_state = S_REM_RD;
                        end
                    end
                    MODE_CLEAR: begin
                        o_cmd.cnt_clear = 1'b1;
                    end
                    MODE_OBSERVE: begin
                        o_cmd.obs_start = 1'b1;
                        n_state = i_sts.cnt_lt2 ? S_OBS_END : S_OBS_RD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_UPD_RD: begin
                n_state = S_UPD_CHK;
            end
            S_UPD_CHK: begin
                if (i_sts.match) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_src = WR_UPD;
                end
                if (i_sts.scan_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_UPD_RD;
                end
            end
            S_REM_RD: begin
                n_state = S_REM_CHK;
            end
            S_REM_CHK: begin
                if (i_sts.match) begin
                    // last entry matched: nothing to move up
                    if (i_sts.scan_end) begin
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_SHF_RD;
                    end
                end else if (i_sts.scan_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_REM_RD;
                end
            end
            S_SHF_RD: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_SHF_WR;
            end
            S_SHF_WR: begin
                o_cmd.rd_next = 1'b1;
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_src  = WR_SHIFT;
                if (i_sts.shift_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SHF_RD;
                end
            end
            S_OBS_RD: begin
                n_state = S_OBS_CHK;
            end
            S_OBS_CHK: begin
                // a new hit pushes the held one out, which needs a free output
                if (!(i_sts.overlap && i_sts.pend_valid && !i_sts.out_free)) begin
                    if (i_sts.overlap) begin
                        o_cmd.pend_push = 1'b1;
                        o_cmd.out_pair  = i_sts.pend_valid;
                    end
                    if (i_sts.pair_end) begin
                        n_state = S_OBS_END;
                    end else begin
                        o_cmd.obs_advance = 1'b1;
                        n_state           = S_OBS_RD;
                    end
                end
            end
            S_OBS_END: begin
                if (i_sts.out_free) begin
                    o_cmd.out_final = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !o_cmd.wr_en)
        else $error("table write while idle");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_pair || o_cmd.out_final) |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    a_add_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cnt_inc |-> !i_sts.full)
        else $error("append into a full table");

endmodule

`default_nettype wire

[design/aabbct_dp.sv]
// Datapath: command latch, table RAM, indexes, overlap test, pending pair and result register.
`default_nettype none

module aabbct_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire aabbct_pkg::t_dp_cmd                   i_cmd,
    output aabbct_pkg::t_dp_sts                        o_sts,
    input  wire logic        [aabbct_pkg::MODE_W-1:0]  i_mode,
    input  wire logic        [aabbct_pkg::TAG_W-1:0]   i_object_id,
    input  wire logic signed [aabbct_pkg::COORD_W-1:0] i_box_left,
    input  wire logic signed [aabbct_pkg::COORD_W-1:0] i_box_top,
    input  wire logic        [aabbct_pkg::SIZE_W-1:0]  i_box_width,
    input  wire logic        [aabbct_pkg::SIZE_W-1:0]  i_box_height,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic             [aabbct_pkg::TAG_W-1:0]   o_first_id,
    output logic             [aabbct_pkg::TAG_W-1:0]   o_second_id,
    output logic                                       o_pair_found,
    output logic                                       o_last
);
    import aabbct_pkg::*;

    function automatic logic boxes_overlap(input logic [BOX_W-1:0] a, input logic [BOX_W-1:0] b);
        logic signed [COORD_W:0] al;
        logic signed [COORD_W:0] at;
        logic signed [COORD_W:0] ar;
        logic signed [COORD_W:0] ab;
        logic signed [COORD_W:0] bl;
        logic signed [COORD_W:0] bt;
        logic signed [COORD_W:0] br;
        logic signed [COORD_W:0] bb;
        al = $signed({a[LEFT_LSB+COORD_W-1], a[LEFT_LSB +: COORD_W]});
        at = $signed({a[TOP_LSB+COORD_W-1], a[TOP_LSB +: COORD_W]});
        bl = $signed({b[LEFT_LSB+COORD_W-1], b[LEFT_LSB +: COORD_W]});
        bt = $signed({b[TOP_LSB+COORD_W-1], b[TOP_LSB +: COORD_W]});
        ar = al + $signed({2'b00, a[WID_LSB +: SIZE_W]});
        ab = at + $signed({2'b00, a[HGT_LSB +: SIZE_W]});
        br = bl + $signed({2'b00, b[WID_LSB +: SIZE_W]});
        bb = bt + $signed({2'b00, b[HGT_LSB +: SIZE_W]});
        // touching edges overlap
        return !(bl > ar || br < al || bt > ab || bb < at);
    endfunction

    // latched command item
    logic [MODE_W-1:0] r_mode;
    logic [TAG_W-1:0]  r_tag;
    logic [BOX_W-1:0]  r_box;

    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_j;
    logic              r_pend_valid;
    logic [TAG_W-1:0]  r_pend_first;
    logic [TAG_W-1:0]  r_pend_second;

    logic              r_out_valid;
    logic [TAG_W-1:0]  r_out_first;
    logic [TAG_W-1:0]  r_out_second;
    logic              r_out_found;
    logic              r_out_last;

    logic [IDX_W-1:0]  wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic [IDX_W-1:0]  rd_addr_a;
    logic [ENT_W-1:0]  rd_data_a;
    logic [ENT_W-1:0]  rd_data_b;
    logic              j_last;
    logic              shift_end;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_mode;
            r_tag  <= i_object_id;
            r_box  <= {i_box_left, i_box_top, i_box_width, i_box_height};
        end
    end

    assign rd_addr_a = i_cmd.rd_next ? r_i + IDX_W'(1) : r_i;
    assign wr_addr   = (i_cmd.wr_src == WR_ADD) ? r_count[IDX_W-1:0] : r_i;

    always_comb begin
        case (i_cmd.wr_src)
            WR_ADD:   wr_data = {r_tag, r_box};
            WR_UPD:   wr_data = {rd_data_a[ENT_W-1 -: TAG_W], r_box};
            WR_SHIFT: wr_data = rd_data_a;
            default:  wr_data = {r_tag, r_box};
        endcase
    end

    aabbct_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_OBJECTS)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (i_cmd.wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (r_j),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    assign j_last    = (CNT_W'(r_j) + CNT_W'(1)) == r_count;
    assign shift_end = (CNT_W'(r_i) + CNT_W'(2)) == r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.cnt_clear) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end

            if (i_cmd.idx_clear) begin
                r_i <= '0;
            end else if (i_cmd.idx_inc) begin
                r_i <= r_i + IDX_W'(1);
            end else if (i_cmd.obs_start) begin
                r_i <= '0;
                r_j <= IDX_W'(1);
            end else if (i_cmd.obs_advance) begin
                if (j_last) begin
                    r_i <= r_i + IDX_W'(1);
                    r_j <= r_i + IDX_W'(2);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end

            if (i_cmd.obs_start) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.pend_push) begin
                r_pend_valid <= 1'b1;
            end

            if (i_cmd.out_pair || i_cmd.out_final) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pend_push) begin
            r_pend_first  <= rd_data_a[ENT_W-1 -: TAG_W];
            r_pend_second <= rd_data_b[ENT_W-1 -: TAG_W];
        end
        if (i_cmd.out_pair) begin
            r_out_first  <= r_pend_first;
            r_out_second <= r_pend_second;
            r_out_found  <= 1'b1;
            r_out_last   <= 1'b0;
        end else if (i_cmd.out_final) begin
            r_out_first  <= r_pend_valid ? r_pend_first : '0;
            r_out_second <= r_pend_valid ? r_pend_second : '0;
            r_out_found  <= r_pend_valid;
            r_out_last   <= 1'b1;
        end
    end

    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.full       = r_count == CNT_W'(MAX_OBJECTS);
        o_sts.cnt_zero   = r_count == '0;
        o_sts.cnt_lt2    = r_count < CNT_W'(2);
        o_sts.match      = rd_data_a[ENT_W-1 -: TAG_W] == r_tag;
        o_sts.scan_end   = (CNT_W'(r_i) + CNT_W'(1)) == r_count;
        o_sts.shift_end  = shift_end;
        o_sts.pair_end   = j_last && shift_end;
        o_sts.overlap    = boxes_overlap(rd_data_a[BOX_W-1:0], rd_data_b[BOX_W-1:0]);
        o_sts.pend_valid = r_pend_valid;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_first_id   = r_out_first;
    assign o_second_id  = r_out_second;
    assign o_pair_found = r_out_found;
    assign o_last       = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_OBJECTS))
        else $error("entry count past table size");

    a_nopair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> r_out_last)
        else $error("empty result not marked last");

    a_final_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_final && !r_pend_valid) |=> (!r_out_found && r_out_last))
        else $error("empty observe run reported a pair");

endmodule

`default_nettype wire

[design/aabb_all_pairs_collision_table_top.sv]
// Top level of the AABB all-pairs collision table: controller, datapath and channel wiring.
// One command transfer at a time; input ready is high only while the controller is idle.
// Add/clear: accept, then dispatch. Update and remove walk the stored entries in order.
// Observe: for each entry pair, a table RAM read, then an overlap test;
// a held-back result transfer stalls the walk. A hit waits for the next hit or the walk's end.
// Reset (sync, active low) empties the table count; stored entries are not cleared.
`default_nettype none

module aabb_all_pairs_collision_table_top (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    aabbct_in_if.sink      i_in,
    aabbct_out_if.source   o_out
);
    import aabbct_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: decodes the mode of the accepted transfer and walks the table.
    aabbct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Table storage, indexes and overlap test. The datapath holds the latest hit
    // back by one so the final pair of a run can carry the last flag; the result
    // register decouples the output side so new commands are taken while a
    // result still waits.
    aabbct_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_in.mode),
        .i_object_id  (i_in.object_id),
        .i_box_left   (i_in.box_left),
        .i_box_top    (i_in.box_top),
        .i_box_width  (i_in.box_width),
        .i_box_height (i_in.box_height),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_first_id   (o_out.first_id),
        .o_second_id  (o_out.second_id),
        .o_pair_found (o_out.pair_found),
        .o_last       (o_out.last)
    );

endmodule

`default_nettype wire
